[rtl/ute_pkg.sv]
// ----------------------------------------------------------------------------
// ute_pkg
// Shared types, constants and helper functions for the trigram extractor.
// ----------------------------------------------------------------------------
package ute_pkg;

  localparam int CODE_W   = 24;
  localparam int BIT_W    = 8;
  localparam int ROW_AW   = CODE_W - BIT_W;
  localparam int ROW_BITS = 1 << BIT_W;
  localparam int ROW_CNT  = 1 << ROW_AW;
  localparam int EPOCH_W  = 16;
  localparam int HASH_W   = 64;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [HASH_W-1:0]  FNV_BASIS   = 64'd14695981039346656037;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [ROW_AW-1:0]  ROW_LAST    = {ROW_AW{1'b1}};

  localparam logic KIND_TRIGRAM = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic [EPOCH_W-1:0]  tag;
    logic [ROW_BITS-1:0] bits;
  } row_t;

  localparam int RAM_W = $bits(row_t);

  typedef struct packed {
    logic              is_tri;
    logic [CODE_W-1:0] code;
    logic              eot;
    logic [HASH_W-1:0] hash;
  } item_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // FNV-1a 64 step; the prime is 2^40 + 0x1B3
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/ute_if.sv]
// ----------------------------------------------------------------------------
// ute_in_if / ute_out_if
// Valid/ready channels for text bytes and result records.
// ----------------------------------------------------------------------------
interface ute_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source(output valid, output data_byte, output end_of_text, input ready);
  modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

interface ute_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [23:0] trigram_code;
  logic [63:0] content_hash;
  logic        last_of_run;

  modport source(output valid, output record_kind, output trigram_code,
                 output content_hash, output last_of_run, input ready);
  modport sink(input valid, input record_kind, input trigram_code,
               input content_hash, input last_of_run, output ready);
endinterface

[rtl/ute_ram.sv]
// ----------------------------------------------------------------------------
// ute_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ute_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ute_rec_queue.sv]
// ----------------------------------------------------------------------------
// ute_rec_queue
// Small result queue; splits one queued item into one or two record beats.
// ----------------------------------------------------------------------------
module ute_rec_queue import ute_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  item_t             push_item,
  output logic [QCNT_W-1:0] free,
  ute_out_if.source         rec_out
);

  item_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              half;
  item_t             head;
  logic              show_tri;
  logic              take;
  logic              pop;

  assign head     = q[rd_ptr];
  assign show_tri = head.is_tri && !half;

  assign rec_out.valid        = (count != '0);
  assign rec_out.record_kind  = show_tri ? KIND_TRIGRAM : KIND_END;
  assign rec_out.trigram_code = show_tri ? head.code : '0;
  assign rec_out.content_hash = show_tri ? '0 : head.hash;
  assign rec_out.last_of_run  = show_tri ? !head.eot : 1'b1;

  assign take = rec_out.valid && rec_out.ready;
  assign pop  = take && rec_out.last_of_run;
  assign free = QCNT_W'(QDEPTH) - count;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
        half   <= 1'b0;
      end else if (take) begin
        half <= 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

[rtl/unique_trigram_extractor_with_hash_unit.sv]
// ----------------------------------------------------------------------------
// unique_trigram_extractor_with_hash_unit
// Per-text unique trigram extraction with FNV-1a 64 content hash.
//
//   channel  | dir | payload                                          | beat
//   text_in  | in  | data_byte, end_of_text                           | one byte
//   rec_out  | out | record_kind, trigram_code, content_hash, last_of_run | one record
//
// One byte per cycle while ready; a byte passes the s1 register, then the queue.
// Seen bitmap: 65536 rows of 256 bits plus an epoch tag, read-modify-write
// with a registered read and a one-deep write forward.
// After reset, and once s1 drains in ST_WAIT after every 65535th text, a clearing
// pass over the 65536 rows runs with text_in.ready low. A trigram plus end record takes
// two beats; text_in stalls unless the queue holds room for the byte in flight too.
// ----------------------------------------------------------------------------
module unique_trigram_extractor_with_hash_unit import ute_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ute_in_if.sink    text_in,
  ute_out_if.source rec_out
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam logic [1:0] HELD_FULL = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [ROW_AW-1:0]  clr_row;
  logic [EPOCH_W-1:0] epoch;
  logic [15:0]        window;
  logic [1:0]         held;
  logic [HASH_W-1:0]  hash;

  logic               s1_valid;
  logic [CODE_W-1:0]  s1_code;
  logic               s1_tri;
  logic               s1_eot;
  logic [HASH_W-1:0]  s1_hash;
  logic [EPOCH_W-1:0] s1_epoch;

  logic               fwd_valid;
  logic [ROW_AW-1:0]  fwd_row;
  row_t               fwd_data;

  logic               in_acc;
  logic [7:0]         low;
  logic [CODE_W-1:0]  code;
  logic [HASH_W-1:0]  hash_next;
  logic [QCNT_W-1:0]  free;

  logic [RAM_W-1:0]   rdata;
  row_t               eff;
  logic [ROW_BITS-1:0] bits;
  logic               seen;
  logic               is_new;
  logic               we;
  logic [ROW_AW-1:0]  waddr;
  row_t               wdata;
  logic               push;
  item_t              push_item;

  assign low       = lower_ascii(text_in.data_byte);
  assign code      = {window, low};
  assign hash_next = fnv_step(hash, text_in.data_byte);

  assign text_in.ready = (state == ST_RUN) && (free > QCNT_W'(s1_valid));
  assign in_acc        = text_in.valid && text_in.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_LAST) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_acc && text_in.end_of_text && epoch == EPOCH_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!s1_valid) begin
          state_next = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_row   <= '0;
      epoch     <= EPOCH_FIRST;
      window    <= '0;
      held      <= '0;
      hash      <= FNV_BASIS;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      state     <= state_next;
      s1_valid  <= in_acc;
      fwd_valid <= we;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + ROW_AW'(1);
      end else begin
        clr_row <= '0;
      end
      if (in_acc) begin
        if (text_in.end_of_text) begin
          window <= '0;
          held   <= '0;
          hash   <= FNV_BASIS;
          epoch  <= (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
        end else begin
          window <= {window[7:0], low};
          held   <= (held == HELD_FULL) ? HELD_FULL : held + 2'd1;
          hash   <= hash_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code  <= code;
      s1_tri   <= (held == HELD_FULL);
      s1_eot   <= text_in.end_of_text;
      s1_hash  <= hash_next;
      s1_epoch <= epoch;
    end
    fwd_row  <= waddr;
    fwd_data <= wdata;
  end

  ute_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ROW_CNT)
  ) u_seen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (in_acc),
    .raddr(code[CODE_W-1:BIT_W]),
    .rdata(rdata)
  );

  always_comb begin
    if (fwd_valid && fwd_row == s1_code[CODE_W-1:BIT_W]) begin
      eff = fwd_data;
    end else begin
      eff = row_t'(rdata);
    end
    bits   = (eff.tag == s1_epoch) ? eff.bits : '0;
    seen   = bits[s1_code[BIT_W-1:0]];
    is_new = s1_valid && s1_tri && !seen;

    if (state == ST_CLEAR) begin
      we         = 1'b1;
      waddr      = clr_row;
      wdata.tag  = '0;
      wdata.bits = '0;
    end else begin
      we         = is_new;
      waddr      = s1_code[CODE_W-1:BIT_W];
      wdata.tag  = s1_epoch;
      wdata.bits = bits | (ROW_BITS'(1) << s1_code[BIT_W-1:0]);
    end
  end

  assign push             = s1_valid && (is_new || s1_eot);
  assign push_item.is_tri = is_new;
  assign push_item.code   = s1_code;
  assign push_item.eot    = s1_eot;
  assign push_item.hash   = s1_hash;

  ute_rec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .free     (free),
    .rec_out  (rec_out)
  );

endmodule

[rtl/ute_checker.sv]
// ----------------------------------------------------------------------------
// ute_checker
// Port-level checks for the trigram extractor, bound to the top level.
// ----------------------------------------------------------------------------
module ute_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [23:0] out_code,
  input logic [63:0] out_hash,
  input logic        out_last
);

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input ready during clearing pass");

  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_kind))
    else $error("non-final beat not followed by end record");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind) |-> (out_last && out_code == 24'd0))
    else $error("end record malformed");

  a_trigram_no_hash: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_kind) |-> (out_hash == 64'd0))
    else $error("trigram record carries hash");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_hash)))
    else $error("stalled beat changed");

endmodule

bind unique_trigram_extractor_with_hash_unit ute_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (text_in.ready),
  .out_valid(rec_out.valid),
  .out_ready(rec_out.ready),
  .out_kind (rec_out.record_kind),
  .out_code (rec_out.trigram_code),
  .out_hash (rec_out.content_hash),
  .out_last (rec_out.last_of_run)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives texts byte by byte into the unique trigram extractor and checks every
// record against a predictor that tracks the running hash, the lower-cased
// window and the set of trigrams seen in the current text. Directed texts
// cover case folding, short texts and repeated trigrams. Random texts follow,
// with idle cycles on both channels and one stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import ute_pkg::*;

  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;
  localparam int          MAX_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic        kind;
    logic [23:0] code;
    logic [63:0] hash;
    logic        last;
  } record_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ute_in_if  text_in();
  ute_out_if rec_out();

  unique_trigram_extractor_with_hash_unit i_dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_in),
    .rec_out(rec_out)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [63:0] text_hash;
  logic [15:0] window;
  int          held;
  bit          seen_codes[logic [23:0]];
  record_t     pending_records[$];

  int  error_count;
  int  cycle_count;
  int  bytes_sent;
  bit  calm;

  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    logic [7:0]  low;
    logic [23:0] code;
    record_t     rec;
    low = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    text_hash = (text_hash ^ {56'd0, b}) * HASH_PRIME;
    if (held >= 2) begin
      code = {window, low};
      if (!seen_codes.exists(code)) begin
        seen_codes[code] = 1'b1;
        rec.kind = KIND_TRIGRAM;
        rec.code = code;
        rec.hash = '0;
        rec.last = ~eot;
        pending_records.insert(pending_records.size(), rec);
      end
    end
    window = {window[7:0], low};
    if (held < 2) held++;
    if (eot) begin
      rec.kind = KIND_END;
      rec.code = '0;
      rec.hash = text_hash;
      rec.last = 1'b1;
      pending_records.insert(pending_records.size(), rec);
      text_hash = FNV_BASIS;
      window = '0;
      held = 0;
      seen_codes.delete();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(99) < 16) begin
      text_in.valid <= 1'b0;
      @(negedge clk);
    end
    text_in.valid       <= 1'b1;
    text_in.data_byte   <= b;
    text_in.end_of_text <= eot;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    predict_byte(b, eot);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] pick_byte(input int mode);
    logic [7:0] edges [10] = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B,
                               8'h60, 8'h61, 8'h7A, 8'h7B};
    logic [7:0] b;
    case (mode)
      0: begin
        b = 8'($urandom_range(255));
      end
      1: begin
        b = 8'h61 + 8'($urandom_range(3));
        if ($urandom_range(1)) b = b - 8'h20;
      end
      default: begin
        b = edges[$urandom_range(9)];
      end
    endcase
    return b;
  endfunction

  task automatic send_random_text();
    int len;
    int mode;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(24, 1);
    else if (pick < 95) len = $urandom_range(80, 25);
    else len = $urandom_range(300, 150);
    pick = $urandom_range(99);
    mode = (pick < 50) ? 1 : (pick < 80) ? 0 : 2;
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(mode), i == len - 1);
    end
  endtask

  task automatic test_short_texts();
    send_string("A");
    send_string("zZ");
  endtask

  task automatic test_case_folding();
    send_string("ABCabc");
  endtask

  task automatic test_boundary_bytes();
    logic [7:0] seq [8] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h5A, 8'h41};
    for (int i = 0; i < 8; i++) begin
      send_byte(seq[i], i == 7);
    end
  endtask

  task automatic test_bitmap_clear();
    send_string("abab");
    send_string("ABAB");
  endtask

  task automatic test_random_texts(input int target);
    while (bytes_sent < target) send_random_text();
  endtask

  task automatic test_full_rate(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    calm = 1'b1;
    while (bytes_sent < stop_at) send_random_text();
    calm = 1'b0;
  endtask

  // result sink: random backpressure
  always @(negedge clk) begin
    rec_out.ready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    record_t got;
    record_t exp;
    if (!rst && rec_out.valid && rec_out.ready) begin
      got.kind = rec_out.record_kind;
      got.code = rec_out.trigram_code;
      got.hash = rec_out.content_hash;
      got.last = rec_out.last_of_run;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record kind=%0d code=%06h hash=%016h last=%0d",
                 $time, got.kind, got.code, got.hash, got.last);
        error_count++;
      end else begin
        exp = pending_records.pop_front();
        if (got !== exp) begin
          $display("%0t: record mismatch expected kind=%0d code=%06h hash=%016h last=%0d",
                   $time, exp.kind, exp.code, exp.hash, exp.last);
          $display("%0t:                   actual kind=%0d code=%06h hash=%016h last=%0d",
                   $time, got.kind, got.code, got.hash, got.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    text_in.valid       = 1'b0;
    text_in.data_byte   = '0;
    text_in.end_of_text = 1'b0;
    text_hash   = FNV_BASIS;
    window      = '0;
    held        = 0;
    error_count = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    calm        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_texts();
    test_case_folding();
    test_boundary_bytes();
    test_bitmap_clear();
    test_random_texts(700);
    test_full_rate(250);
    test_random_texts(1400);

    text_in.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ute_pkg.sv
rtl/ute_if.sv
rtl/ute_ram.sv
rtl/ute_rec_queue.sv
rtl/unique_trigram_extractor_with_hash_unit.sv
rtl/ute_checker.sv
test/testbench.sv
